>>> rtl/bfa_pkg.sv
`timescale 1ns / 1ps

package bfa_pkg;

    localparam int ARENA_UNITS = 2048;
    localparam int UNIT_BYTES  = 2;
    localparam int ADDR_W      = 11;
    localparam int WORD_W      = 16;
    localparam int VAL_W       = 18;
    localparam int CNT_W       = 12;
    localparam int SIZE_W      = 13;
    localparam int HEAD_W      = 16;
    localparam int STEP_W      = 12;

    localparam logic ACT_ALLOC    = 1'b0;
    localparam logic ACT_FREE     = 1'b1;
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_NOFIT = 1'b1;

    typedef logic signed [VAL_W-1:0] val_t;

    typedef struct packed {
        logic               action;
        val_t               units;
        logic [SIZE_W-1:0]  mask;
        logic [ADDR_W-1:0]  offset;
    } req_t;

    typedef struct packed {
        logic               status;
        logic [ADDR_W-1:0]  granted;
        logic [CNT_W-1:0]   free_total;
    } res_t;

    typedef struct packed {
        logic idle;
        logic done;
    } eng_stat_t;

    // bytes to units, zero bytes counts as one unit
    function automatic val_t units_of(input logic [SIZE_W-1:0] size);
        logic [SIZE_W:0] sum;
        logic [SIZE_W:0] q;
        sum = {1'b0, size} + (SIZE_W+1)'(UNIT_BYTES - 1);
        q   = sum / (SIZE_W+1)'(UNIT_BYTES);
        if (q == '0) begin
            q = (SIZE_W+1)'(1);
        end
        return val_t'({{(VAL_W-SIZE_W-1){1'b0}}, q});
    endfunction

    // low mask below the highest set bit of the alignment
    function automatic logic [SIZE_W-1:0] align_mask(input logic [SIZE_W-1:0] align);
        logic [SIZE_W-1:0] m;
        m = '0;
        for (int i = 0; i < SIZE_W - 1; i++) begin
            m[i] = |(align >> (i + 1));
        end
        return m;
    endfunction

endpackage

>>> rtl/bfa_arena.sv
`timescale 1ns / 1ps

module bfa_arena (
    input  logic                        aclk,
    input  logic                        we,
    input  bfa_pkg::val_t               addr,
    input  logic [bfa_pkg::WORD_W-1:0]  wdata,
    output logic [bfa_pkg::WORD_W-1:0]  rdata
);

    logic [bfa_pkg::WORD_W-1:0] mem [bfa_pkg::ARENA_UNITS];
    logic [bfa_pkg::WORD_W-1:0] rdata_reg;
    logic                       in_range;
    logic [bfa_pkg::ADDR_W-1:0] idx;

    assign in_range = (addr >= 0) && (addr < bfa_pkg::val_t'(bfa_pkg::ARENA_UNITS));
    assign idx      = addr[bfa_pkg::ADDR_W-1:0];

    // out-of-arena reads return zero, writes are dropped
    always_ff @(posedge aclk) begin
        if (we && in_range) begin
            mem[idx] <= wdata;
        end
        rdata_reg <= in_range ? mem[idx] : '0;
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/bfa_seq.sv
`timescale 1ns / 1ps

module bfa_seq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  bfa_pkg::req_t        req,
    input  logic                 res_take,
    output bfa_pkg::res_t        res,
    output bfa_pkg::eng_stat_t   stat
);

    typedef enum logic [26:0] {
        S_CLEAR     = 27'd1 << 0,
        S_IDLE      = 27'd1 << 1,
        S_LD0       = 27'd1 << 2,
        S_LD1       = 27'd1 << 3,
        S_LD2       = 27'd1 << 4,
        S_PUT0      = 27'd1 << 5,
        S_PUT1      = 27'd1 << 6,
        S_DONE      = 27'd1 << 7,
        S_A_START   = 27'd1 << 8,
        S_A_EVAL    = 27'd1 << 9,
        S_A_CHOSE   = 27'd1 << 10,
        S_A_PICK    = 27'd1 << 11,
        S_A_HEAD2   = 27'd1 << 12,
        S_A_HEAD3   = 27'd1 << 13,
        S_A_SPLIT   = 27'd1 << 14,
        S_A_LINK    = 27'd1 << 15,
        S_A_TAIL    = 27'd1 << 16,
        S_A_FIN     = 27'd1 << 17,
        S_F_START   = 27'd1 << 18,
        S_F_HMRG    = 27'd1 << 19,
        S_F_SETHEAD = 27'd1 << 20,
        S_F_WALK    = 27'd1 << 21,
        S_F_PREV    = 27'd1 << 22,
        S_F_NMRG    = 27'd1 << 23,
        S_F_LDB     = 27'd1 << 24,
        S_F_LDP     = 27'd1 << 25,
        S_F_LINK    = 27'd1 << 26
    } state_t;

    localparam bfa_pkg::val_t ARENA_V = bfa_pkg::val_t'(bfa_pkg::ARENA_UNITS);
    localparam bfa_pkg::val_t ONE_V   = bfa_pkg::val_t'(1);

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    state_t put_ret_reg, put_ret_next;

    bfa_pkg::val_t ld_addr_reg, ld_addr_next;
    bfa_pkg::val_t lu_reg, lu_next;
    bfa_pkg::val_t ln_reg, ln_next;
    bfa_pkg::val_t put_s_reg, put_s_next;
    bfa_pkg::val_t put_size_reg, put_size_next;
    bfa_pkg::val_t put_nx_reg, put_nx_next;

    logic                        act_reg, act_next;
    bfa_pkg::val_t               units_reg, units_next;
    logic [bfa_pkg::SIZE_W-1:0]  mask_reg, mask_next;
    bfa_pkg::val_t               b_reg, b_next;

    bfa_pkg::val_t cur_reg, cur_next;
    bfa_pkg::val_t prev_reg, prev_next;
    logic          prev_ok_reg, prev_ok_next;
    logic [bfa_pkg::STEP_W-1:0] steps_reg, steps_next;
    logic          found_reg, found_next;
    bfa_pkg::val_t bcur_reg, bcur_next;
    bfa_pkg::val_t bprev_reg, bprev_next;
    logic          bprev_ok_reg, bprev_ok_next;
    bfa_pkg::val_t bdelta_reg, bdelta_next;
    bfa_pkg::val_t bleft_reg, bleft_next;
    bfa_pkg::val_t avail_reg, avail_next;
    bfa_pkg::val_t nsave_reg, nsave_next;

    logic [bfa_pkg::HEAD_W-1:0] head_reg, head_next;
    logic [bfa_pkg::CNT_W-1:0]  count_reg, count_next;
    logic                       has_free_reg, has_free_next;
    logic [bfa_pkg::ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic                       clr_free_reg, clr_free_next;
    logic                       status_reg, status_next;
    logic [bfa_pkg::ADDR_W-1:0] grant_reg, grant_next;

    logic                        mem_we;
    bfa_pkg::val_t               mem_addr;
    logic [bfa_pkg::WORD_W-1:0]  mem_wdata;
    logic [bfa_pkg::WORD_W-1:0]  mem_rdata;

    bfa_pkg::val_t rv;
    bfa_pkg::val_t head_v;
    bfa_pkg::val_t count_v;
    bfa_pkg::val_t put_neg;
    bfa_pkg::val_t delta;
    bfa_pkg::val_t need;
    logic [bfa_pkg::SIZE_W-1:0] cb;
    logic [bfa_pkg::SIZE_W-1:0] gap;
    logic [bfa_pkg::SIZE_W-1:0] gap_units;
    logic          fit;
    logic          ln_end;

    bfa_arena u_arena (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign rv      = {{(bfa_pkg::VAL_W-bfa_pkg::WORD_W){mem_rdata[bfa_pkg::WORD_W-1]}}, mem_rdata};
    assign head_v  = {{(bfa_pkg::VAL_W-bfa_pkg::HEAD_W){1'b0}}, head_reg};
    assign count_v = {{(bfa_pkg::VAL_W-bfa_pkg::CNT_W){1'b0}}, count_reg};
    assign put_neg = -put_nx_reg;
    assign ln_end  = (ln_reg <= 0) || (ln_reg >= ARENA_V);

    // alignment head of the current block, in units
    assign cb        = bfa_pkg::SIZE_W'(cur_reg) * bfa_pkg::SIZE_W'(bfa_pkg::UNIT_BYTES);
    assign gap       = (~cb + bfa_pkg::SIZE_W'(1)) & mask_reg;
    assign gap_units = gap / bfa_pkg::SIZE_W'(bfa_pkg::UNIT_BYTES);
    assign delta     = {{(bfa_pkg::VAL_W-bfa_pkg::SIZE_W){1'b0}}, gap_units};
    assign need      = units_reg + delta;
    assign fit       = (lu_reg >= need) && (cur_reg + need <= ARENA_V) &&
                       (!found_reg || (lu_reg - need < bleft_reg));

    always_comb begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        put_ret_next  = put_ret_reg;
        ld_addr_next  = ld_addr_reg;
        lu_next       = lu_reg;
        ln_next       = ln_reg;
        put_s_next    = put_s_reg;
        put_size_next = put_size_reg;
        put_nx_next   = put_nx_reg;
        act_next      = act_reg;
        units_next    = units_reg;
        mask_next     = mask_reg;
        b_next        = b_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        prev_ok_next  = prev_ok_reg;
        steps_next    = steps_reg;
        found_next    = found_reg;
        bcur_next     = bcur_reg;
        bprev_next    = bprev_reg;
        bprev_ok_next = bprev_ok_reg;
        bdelta_next   = bdelta_reg;
        bleft_next    = bleft_reg;
        avail_next    = avail_reg;
        nsave_next    = nsave_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        has_free_next = has_free_reg;
        clr_cnt_next  = clr_cnt_reg;
        clr_free_next = clr_free_reg;
        status_next   = status_reg;
        grant_next    = grant_reg;
        mem_we        = 1'b0;
        mem_addr      = ld_addr_reg;
        mem_wdata     = '0;

        unique case (state_reg)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = {{(bfa_pkg::VAL_W-bfa_pkg::ADDR_W){1'b0}}, clr_cnt_reg};
                mem_wdata = (clr_cnt_reg < bfa_pkg::ADDR_W'(2)) ?
                            bfa_pkg::WORD_W'(bfa_pkg::ARENA_UNITS) : '0;
                clr_cnt_next = clr_cnt_reg + bfa_pkg::ADDR_W'(1);
                if (clr_cnt_reg == bfa_pkg::ADDR_W'(bfa_pkg::ARENA_UNITS - 1)) begin
                    state_next = clr_free_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    act_next    = req.action;
                    units_next  = req.units;
                    mask_next   = req.mask;
                    b_next      = {{(bfa_pkg::VAL_W-bfa_pkg::ADDR_W){1'b0}}, req.offset};
                    status_next = bfa_pkg::STATUS_OK;
                    grant_next  = '0;
                    state_next  = (req.action == bfa_pkg::ACT_FREE) ? S_F_START : S_A_START;
                end
            end
            // block load: units and next offset of the block at ld_addr
            S_LD0: begin
                mem_addr   = ld_addr_reg;
                state_next = S_LD1;
            end
            S_LD1: begin
                mem_addr = ld_addr_reg + ONE_V;
                lu_next  = (rv > 0) ? rv : ONE_V;
                if (rv < 0) begin
                    ln_next    = -rv;
                    state_next = ret_reg;
                end else begin
                    state_next = S_LD2;
                end
            end
            S_LD2: begin
                ln_next    = rv;
                state_next = ret_reg;
            end
            // block store: size and next, or minus next for a one-unit block
            S_PUT0: begin
                mem_we   = 1'b1;
                mem_addr = put_s_reg;
                if (put_size_reg > ONE_V) begin
                    mem_wdata  = put_size_reg[bfa_pkg::WORD_W-1:0];
                    state_next = S_PUT1;
                end else begin
                    mem_wdata  = put_neg[bfa_pkg::WORD_W-1:0];
                    state_next = put_ret_reg;
                end
            end
            S_PUT1: begin
                mem_we     = 1'b1;
                mem_addr   = put_s_reg + ONE_V;
                mem_wdata  = put_nx_reg[bfa_pkg::WORD_W-1:0];
                state_next = put_ret_reg;
            end
            S_DONE: begin
                if (res_take) begin
                    state_next = S_IDLE;
                end
            end
            S_A_START: begin
                if (!has_free_reg || (units_reg > count_v) || (head_v >= ARENA_V)) begin
                    status_next = bfa_pkg::STATUS_NOFIT;
                    state_next  = S_DONE;
                end else begin
                    cur_next     = head_v;
                    prev_ok_next = 1'b0;
                    found_next   = 1'b0;
                    steps_next   = '0;
                    ld_addr_next = head_v;
                    ret_next     = S_A_EVAL;
                    state_next   = S_LD0;
                end
            end
            S_A_EVAL: begin
                if (fit) begin
                    bprev_next    = prev_reg;
                    bprev_ok_next = prev_ok_reg;
                    bcur_next     = cur_reg;
                    bdelta_next   = delta;
                    bleft_next    = lu_reg - need;
                    found_next    = 1'b1;
                end
                if (ln_end || (steps_reg == bfa_pkg::STEP_W'(bfa_pkg::ARENA_UNITS - 1))) begin
                    state_next = S_A_CHOSE;
                end else begin
                    prev_next    = cur_reg;
                    prev_ok_next = 1'b1;
                    cur_next     = ln_reg;
                    steps_next   = steps_reg + bfa_pkg::STEP_W'(1);
                    ld_addr_next = ln_reg;
                    ret_next     = S_A_EVAL;
                    state_next   = S_LD0;
                end
            end
            S_A_CHOSE: begin
                if (!found_reg) begin
                    status_next = bfa_pkg::STATUS_NOFIT;
                    state_next  = S_DONE;
                end else begin
                    ld_addr_next = bcur_reg;
                    ret_next     = S_A_PICK;
                    state_next   = S_LD0;
                end
            end
            S_A_PICK: begin
                avail_next = lu_reg;
                nsave_next = ln_reg;
                if (bdelta_reg != 0) begin
                    // split off the alignment head
                    put_s_next    = bcur_reg + bdelta_reg;
                    put_size_next = lu_reg - bdelta_reg;
                    put_nx_next   = ln_reg;
                    put_ret_next  = S_A_HEAD2;
                    state_next    = S_PUT0;
                end else begin
                    state_next = S_A_SPLIT;
                end
            end
            S_A_HEAD2: begin
                put_s_next    = bcur_reg;
                put_size_next = bdelta_reg;
                put_nx_next   = bcur_reg + bdelta_reg;
                put_ret_next  = S_A_HEAD3;
                state_next    = S_PUT0;
            end
            S_A_HEAD3: begin
                bprev_next    = bcur_reg;
                bprev_ok_next = 1'b1;
                bcur_next     = bcur_reg + bdelta_reg;
                bdelta_next   = '0;
                ld_addr_next  = bcur_reg + bdelta_reg;
                ret_next      = S_A_PICK;
                state_next    = S_LD0;
            end
            S_A_SPLIT: begin
                if (bprev_ok_reg) begin
                    ld_addr_next = bprev_reg;
                    ret_next     = S_A_LINK;
                    state_next   = S_LD0;
                end else if (avail_reg == units_reg) begin
                    head_next  = nsave_reg[bfa_pkg::HEAD_W-1:0];
                    state_next = S_A_FIN;
                end else begin
                    head_next     = bfa_pkg::HEAD_W'(bcur_reg + units_reg);
                    put_s_next    = bcur_reg + units_reg;
                    put_size_next = avail_reg - units_reg;
                    put_nx_next   = nsave_reg;
                    put_ret_next  = S_A_FIN;
                    state_next    = S_PUT0;
                end
            end
            S_A_LINK: begin
                put_s_next    = bprev_reg;
                put_size_next = lu_reg;
                state_next    = S_PUT0;
                if (avail_reg == units_reg) begin
                    put_nx_next  = nsave_reg;
                    put_ret_next = S_A_FIN;
                end else begin
                    put_nx_next  = bcur_reg + units_reg;
                    put_ret_next = S_A_TAIL;
                end
            end
            S_A_TAIL: begin
                put_s_next    = bcur_reg + units_reg;
                put_size_next = avail_reg - units_reg;
                put_nx_next   = nsave_reg;
                put_ret_next  = S_A_FIN;
                state_next    = S_PUT0;
            end
            S_A_FIN: begin
                count_next    = count_reg - bfa_pkg::CNT_W'(units_reg);
                has_free_next = (count_reg != bfa_pkg::CNT_W'(units_reg));
                grant_next    = bcur_reg[bfa_pkg::ADDR_W-1:0];
                state_next    = S_DONE;
            end
            S_F_START: begin
                if (b_reg + units_reg > ARENA_V) begin
                    state_next = S_DONE;
                end else if (count_v + units_reg >= ARENA_V) begin
                    // whole arena free again: rebuild it
                    head_next     = '0;
                    count_next    = bfa_pkg::CNT_W'(bfa_pkg::ARENA_UNITS);
                    has_free_next = 1'b1;
                    clr_cnt_next  = '0;
                    clr_free_next = 1'b1;
                    state_next    = S_CLEAR;
                end else if (!has_free_reg) begin
                    count_next    = bfa_pkg::CNT_W'(units_reg);
                    head_next     = bfa_pkg::HEAD_W'(b_reg);
                    has_free_next = 1'b1;
                    put_s_next    = b_reg;
                    put_size_next = units_reg;
                    put_nx_next   = ARENA_V;
                    put_ret_next  = S_DONE;
                    state_next    = S_PUT0;
                end else begin
                    count_next = count_reg + bfa_pkg::CNT_W'(units_reg);
                    if (b_reg < head_v) begin
                        if (b_reg + units_reg == head_v) begin
                            ld_addr_next = head_v;
                            ret_next     = S_F_HMRG;
                            state_next   = S_LD0;
                        end else begin
                            put_s_next    = b_reg;
                            put_size_next = units_reg;
                            put_nx_next   = head_v;
                            put_ret_next  = S_F_SETHEAD;
                            state_next    = S_PUT0;
                        end
                    end else begin
                        prev_next    = head_v;
                        steps_next   = '0;
                        ld_addr_next = head_v;
                        ret_next     = S_F_WALK;
                        state_next   = S_LD0;
                    end
                end
            end
            S_F_HMRG: begin
                put_s_next    = b_reg;
                put_size_next = units_reg + lu_reg;
                put_nx_next   = ln_reg;
                put_ret_next  = S_F_SETHEAD;
                state_next    = S_PUT0;
            end
            S_F_SETHEAD: begin
                head_next  = bfa_pkg::HEAD_W'(b_reg);
                state_next = S_DONE;
            end
            S_F_WALK: begin
                nsave_next = ln_reg;
                if ((steps_reg < bfa_pkg::STEP_W'(bfa_pkg::ARENA_UNITS)) && (b_reg > ln_reg)) begin
                    prev_next    = ln_reg;
                    steps_next   = steps_reg + bfa_pkg::STEP_W'(1);
                    ld_addr_next = ln_reg;
                    ret_next     = S_F_WALK;
                end else begin
                    ld_addr_next = prev_reg;
                    ret_next     = S_F_PREV;
                end
                state_next = S_LD0;
            end
            S_F_PREV: begin
                if (!ln_end && (b_reg + units_reg == nsave_reg)) begin
                    ld_addr_next = nsave_reg;
                    ret_next     = S_F_NMRG;
                    state_next   = S_LD0;
                end else begin
                    put_s_next    = b_reg;
                    put_size_next = units_reg;
                    put_nx_next   = nsave_reg;
                    put_ret_next  = S_F_LDB;
                    state_next    = S_PUT0;
                end
            end
            S_F_NMRG: begin
                put_s_next    = b_reg;
                put_size_next = units_reg + lu_reg;
                put_nx_next   = ln_reg;
                put_ret_next  = S_F_LDB;
                state_next    = S_PUT0;
            end
            S_F_LDB: begin
                ld_addr_next = b_reg;
                ret_next     = S_F_LDP;
                state_next   = S_LD0;
            end
            S_F_LDP: begin
                avail_next   = lu_reg;
                nsave_next   = ln_reg;
                ld_addr_next = prev_reg;
                ret_next     = S_F_LINK;
                state_next   = S_LD0;
            end
            S_F_LINK: begin
                put_s_next   = prev_reg;
                put_ret_next = S_DONE;
                state_next   = S_PUT0;
                if (prev_reg + lu_reg == b_reg) begin
                    put_size_next = avail_reg + lu_reg;
                    put_nx_next   = nsave_reg;
                end else begin
                    put_size_next = lu_reg;
                    put_nx_next   = b_reg;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            ret_reg       <= S_IDLE;
            put_ret_reg   <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= bfa_pkg::CNT_W'(bfa_pkg::ARENA_UNITS);
            has_free_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            clr_free_reg  <= 1'b0;
            found_reg     <= 1'b0;
            prev_ok_reg   <= 1'b0;
            bprev_ok_reg  <= 1'b0;
            steps_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            put_ret_reg   <= put_ret_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            has_free_reg  <= has_free_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_free_reg  <= clr_free_next;
            found_reg     <= found_next;
            prev_ok_reg   <= prev_ok_next;
            bprev_ok_reg  <= bprev_ok_next;
            steps_reg     <= steps_next;
        end
    end

    always_ff @(posedge aclk) begin
        ld_addr_reg  <= ld_addr_next;
        lu_reg       <= lu_next;
        ln_reg       <= ln_next;
        put_s_reg    <= put_s_next;
        put_size_reg <= put_size_next;
        put_nx_reg   <= put_nx_next;
        act_reg      <= act_next;
        units_reg    <= units_next;
        mask_reg     <= mask_next;
        b_reg        <= b_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        bcur_reg     <= bcur_next;
        bprev_reg    <= bprev_next;
        bdelta_reg   <= bdelta_next;
        bleft_reg    <= bleft_next;
        avail_reg    <= avail_next;
        nsave_reg    <= nsave_next;
        status_reg   <= status_next;
        grant_reg    <= grant_next;
    end

    // a free always reports a zero offset
    assign res.status     = status_reg;
    assign res.granted    = (act_reg == bfa_pkg::ACT_FREE) ? '0 : grant_reg;
    assign res.free_total = count_reg;
    assign stat.idle      = (state_reg == S_IDLE);
    assign stat.done      = (state_reg == S_DONE);

endmodule

>>> rtl/best_fit_block_allocator.sv
`timescale 1ns / 1ps

// Channel  Direction  Beat contents
// s_       in         s_action, s_size_bytes, s_align_bytes, s_block_offset
// m_       out        m_status, m_granted_offset, m_free_total
//
// One item at a time: s_ready is low from an accepted beat until its result is in m_.
// Allocate walks the in-arena free list, reading one or two words per free block
// on the single arena port, then splits and relinks the chosen block.
// Free walks the list the same way to the insert point, then links the freed block in.
// After reset, and on a free that releases the whole arena, a clearing pass writes all
// 2048 arena words, one per cycle; s_ready stays low during it.
// A waiting m_ beat does not block the next s_ beat.
module best_fit_block_allocator (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_action,
    input  logic [bfa_pkg::SIZE_W-1:0]    s_size_bytes,
    input  logic [bfa_pkg::SIZE_W-1:0]    s_align_bytes,
    input  logic [bfa_pkg::ADDR_W-1:0]    s_block_offset,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_status,
    output logic [bfa_pkg::ADDR_W-1:0]    m_granted_offset,
    output logic [bfa_pkg::CNT_W-1:0]     m_free_total
);

    bfa_pkg::req_t      req;
    bfa_pkg::res_t      res;
    bfa_pkg::eng_stat_t stat;
    logic               start;
    logic               slot_free;
    logic               m_valid_reg;
    bfa_pkg::res_t      m_res_reg;

    assign s_ready    = stat.idle;
    assign start      = s_valid && s_ready;
    assign slot_free  = !m_valid_reg || m_ready;

    assign req.action = s_action;
    assign req.units  = bfa_pkg::units_of(s_size_bytes);
    assign req.mask   = bfa_pkg::align_mask(s_align_bytes);
    assign req.offset = s_block_offset;

    bfa_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .req      (req),
        .res_take (slot_free),
        .res      (res),
        .stat     (stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (stat.done && slot_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // hold the result beat until taken
    always_ff @(posedge aclk) begin
        if (stat.done && slot_free) begin
            m_res_reg <= res;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_res_reg.status;
    assign m_granted_offset = m_res_reg.granted;
    assign m_free_total     = m_res_reg.free_total;

endmodule

>>> rtl/bfa_checker.sv
`timescale 1ns / 1ps

module bfa_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic                          m_status,
    input logic [bfa_pkg::ADDR_W-1:0]    m_granted_offset,
    input logic [bfa_pkg::CNT_W-1:0]     m_free_total
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat present after reset");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a beat is in work");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == bfa_pkg::STATUS_NOFIT)) |-> (m_granted_offset == '0))
        else $error("failed allocate carries an offset");

    a_free_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_free_total <= bfa_pkg::CNT_W'(bfa_pkg::ARENA_UNITS)))
        else $error("free total beyond arena");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_free_total) && $stable(m_status)))
        else $error("stalled result beat changed");

endmodule

bind best_fit_block_allocator bfa_checker u_bfa_checker (.*);

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int LIMIT_CYCLES = 20000000;
    localparam int RANDOM_ITEMS = 270;
    localparam int DIRECTED_ROWS = 23;

    typedef struct {
        logic        action;
        int          size;
        int          align;
        int          offset;
    } req_item_t;

    typedef struct {
        logic        status;
        logic [10:0] granted;
        logic [11:0] total;
    } alloc_res_t;

    typedef struct {
        logic        action;
        int          size;
        int          align;
        int          offset;
        bit          typed;
        logic        status;
        int          granted;
        int          total;
    } table_row_t;

    typedef struct {
        int start;
        int units;
    } live_blk_t;

    logic                        aclk;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    logic                        s_action;
    logic [bfa_pkg::SIZE_W-1:0]  s_size_bytes;
    logic [bfa_pkg::SIZE_W-1:0]  s_align_bytes;
    logic [bfa_pkg::ADDR_W-1:0]  s_block_offset;
    logic                        m_valid;
    logic                        m_ready;
    logic                        m_status;
    logic [bfa_pkg::ADDR_W-1:0]  m_granted_offset;
    logic [bfa_pkg::CNT_W-1:0]   m_free_total;

    best_fit_block_allocator uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_size_bytes    (s_size_bytes),
        .s_align_bytes   (s_align_bytes),
        .s_block_offset  (s_block_offset),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_granted_offset(m_granted_offset),
        .m_free_total    (m_free_total)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // shadow allocator state
    logic [15:0] arena [bfa_pkg::ARENA_UNITS];
    int          shadow_head;
    int          free_units;
    bit          list_valid;

    alloc_res_t  pending_results[$];
    live_blk_t   live_blocks[$];
    int          errors = 0;
    int          cycles = 0;
    bit          no_idle;

    function automatic int word_at(int i);
        if (i < 0 || i >= bfa_pkg::ARENA_UNITS) begin
            return 0;
        end
        return int'($signed(arena[i]));
    endfunction

    function automatic void put_word(int i, int v);
        if (i >= 0 && i < bfa_pkg::ARENA_UNITS) begin
            arena[i] = v[15:0];
        end
    endfunction

    function automatic int blk_len(int s);
        int v;
        v = word_at(s);
        return (v > 0) ? v : 1;
    endfunction

    function automatic int blk_link(int s);
        int v;
        v = word_at(s);
        return (v < 0) ? -v : word_at(s + 1);
    endfunction

    function automatic bit list_end(int n);
        return (n <= 0 || n >= bfa_pkg::ARENA_UNITS);
    endfunction

    function automatic void put_blk(int s, int size, int nxt);
        if (size > 1) begin
            put_word(s, size);
            put_word(s + 1, nxt);
        end else begin
            put_word(s, -nxt);
        end
    endfunction

    function automatic void arena_clear();
        for (int i = 0; i < bfa_pkg::ARENA_UNITS; i++) begin
            arena[i] = '0;
        end
        put_blk(0, bfa_pkg::ARENA_UNITS, bfa_pkg::ARENA_UNITS);
        shadow_head = 0;
        free_units  = bfa_pkg::ARENA_UNITS;
        list_valid  = 1'b1;
        live_blocks.delete();
    endfunction

    function automatic int best_fit_alloc(int units, int align);
        int          prev, cur, b_prev, b_cur, b_delta, b_left, avail, nxt, delta, need, al;
        int unsigned a, cb, ab;
        prev = -1;
        cur = shadow_head;
        b_prev = -1;
        b_cur = -1;
        b_delta = 0;
        b_left = 0;
        a = align;
        if (!list_valid || units > free_units || cur >= bfa_pkg::ARENA_UNITS) begin
            return -1;
        end
        while ((a & (a - 1)) != 0) begin
            a = a & (a - 1);
        end
        for (int steps = 0; steps < bfa_pkg::ARENA_UNITS; steps++) begin
            delta = 0;
            avail = blk_len(cur);
            if (a != 0) begin
                cb = cur * bfa_pkg::UNIT_BYTES;
                ab = (cb + a - 1) & ~(a - 1);
                delta = (ab - cb) / bfa_pkg::UNIT_BYTES;
            end
            need = units + delta;
            if (avail >= need && cur + need <= bfa_pkg::ARENA_UNITS &&
                (b_cur < 0 || avail - need < b_left)) begin
                b_prev = prev;
                b_cur = cur;
                b_delta = delta;
                b_left = avail - need;
            end
            nxt = blk_link(cur);
            if (list_end(nxt)) begin
                break;
            end
            prev = cur;
            cur = nxt;
        end
        if (b_cur < 0) begin
            return -1;
        end
        avail = blk_len(b_cur);
        if (b_delta != 0) begin
            al = b_cur + b_delta;
            nxt = blk_link(b_cur);
            put_blk(al, avail - b_delta, nxt);
            put_blk(b_cur, b_delta, al);
            b_prev = b_cur;
            b_cur = al;
            avail = blk_len(b_cur);
        end
        nxt = blk_link(b_cur);
        if (avail == units) begin
            if (b_prev >= 0) begin
                put_blk(b_prev, blk_len(b_prev), nxt);
            end else begin
                shadow_head = nxt & 16'hFFFF;
            end
        end else begin
            if (b_prev >= 0) begin
                put_blk(b_prev, blk_len(b_prev), b_cur + units);
            end else begin
                shadow_head = b_cur + units;
            end
            put_blk(b_cur + units, avail - units, nxt);
        end
        free_units -= units;
        if (free_units == 0) begin
            list_valid = 1'b0;
        end
        return b_cur;
    endfunction

    function automatic void release_blk(int b, int units);
        int hd, prev, nxt;
        hd = shadow_head;
        if (b + units > bfa_pkg::ARENA_UNITS) begin
            return;
        end
        if (free_units + units >= bfa_pkg::ARENA_UNITS) begin
            arena_clear();
            return;
        end
        if (!list_valid) begin
            free_units = units;
            shadow_head = b;
            put_blk(b, units, bfa_pkg::ARENA_UNITS);
            list_valid = 1'b1;
            return;
        end
        free_units += units;
        if (b < hd) begin
            if (b + units == hd) begin
                units += blk_len(hd);
                hd = blk_link(hd);
            end
            put_blk(b, units, hd);
            shadow_head = b;
            return;
        end
        prev = hd;
        nxt = blk_link(prev);
        for (int steps = 0; steps < bfa_pkg::ARENA_UNITS && b > nxt; steps++) begin
            prev = nxt;
            nxt = blk_link(prev);
        end
        if (!list_end(blk_link(prev)) && b + units == nxt) begin
            units += blk_len(nxt);
            put_blk(b, units, blk_link(nxt));
        end else begin
            put_blk(b, units, nxt);
        end
        if (prev + blk_len(prev) == b) begin
            put_blk(prev, blk_len(b) + blk_len(prev), blk_link(b));
        end else begin
            put_blk(prev, blk_len(prev), b);
        end
    endfunction

    function automatic alloc_res_t apply_request(req_item_t it);
        alloc_res_t r;
        int         units, got;
        units = ((it.size & 13'h1FFF) + bfa_pkg::UNIT_BYTES - 1) / bfa_pkg::UNIT_BYTES;
        if (units == 0) begin
            units = 1;
        end
        r.status = bfa_pkg::STATUS_OK;
        r.granted = '0;
        if (it.action == bfa_pkg::ACT_ALLOC) begin
            got = best_fit_alloc(units, it.align & 13'h1FFF);
            if (got < 0) begin
                r.status = bfa_pkg::STATUS_NOFIT;
            end else begin
                r.granted = got[10:0];
                live_blocks.push_back('{got, units});
            end
        end else begin
            release_blk(it.offset & 11'h7FF, units);
        end
        r.total = free_units[11:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        errors++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    endtask

    // drive one beat; gap is the idle time before it
    task automatic send_item(req_item_t it, int gap, bit typed, alloc_res_t known);
        alloc_res_t r;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_action       <= it.action;
        s_size_bytes   <= it.size[bfa_pkg::SIZE_W-1:0];
        s_align_bytes  <= it.align[bfa_pkg::SIZE_W-1:0];
        s_block_offset <= it.offset[bfa_pkg::ADDR_W-1:0];
        s_valid        <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        r = apply_request(it);
        pending_results.push_back(typed ? known : r);
    endtask

    function automatic req_item_t random_request();
        req_item_t it;
        int        pick, idx;
        live_blk_t lb;
        it.align = 0;
        it.offset = $urandom_range(0, 2047);
        if ($urandom_range(0, 99) < 58) begin
            it.action = bfa_pkg::ACT_ALLOC;
            pick = $urandom_range(0, 99);
            if (pick < 80) it.size = $urandom_range(1, 64);
            else if (pick < 95) it.size = $urandom_range(1, 600);
            else it.size = $urandom_range(0, 8191);
            pick = $urandom_range(0, 99);
            if (pick < 35) it.align = 1 << $urandom_range(0, 12);
            else if (pick < 50) it.align = $urandom_range(0, 8191);
        end else begin
            it.action = bfa_pkg::ACT_FREE;
            if (live_blocks.size() > 0 && $urandom_range(0, 9) < 8) begin
                idx = $urandom_range(0, live_blocks.size() - 1);
                lb = live_blocks[idx];
                live_blocks.delete(idx);
                it.offset = lb.start;
                it.size = lb.units * bfa_pkg::UNIT_BYTES - $urandom_range(0, 1);
                it.align = $urandom_range(0, 8191);
            end else begin
                it.size = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                                      : $urandom_range(1, 64);
            end
        end
        return it;
    endfunction

    table_row_t directed [DIRECTED_ROWS] = '{
        '{bfa_pkg::ACT_ALLOC, 0,    0,    0,    1, bfa_pkg::STATUS_OK,    0,   2047},
        '{bfa_pkg::ACT_ALLOC, 8191, 0,    0,    1, bfa_pkg::STATUS_NOFIT, 0,   2047},
        '{bfa_pkg::ACT_FREE,  4,    0,    2047, 1, bfa_pkg::STATUS_OK,    0,   2047},
        '{bfa_pkg::ACT_FREE,  1,    0,    0,    1, bfa_pkg::STATUS_OK,    0,   2048},
        '{bfa_pkg::ACT_ALLOC, 4096, 0,    0,    1, bfa_pkg::STATUS_OK,    0,   0},
        '{bfa_pkg::ACT_ALLOC, 1,    0,    0,    1, bfa_pkg::STATUS_NOFIT, 0,   0},
        '{bfa_pkg::ACT_FREE,  40,   0,    100,  1, bfa_pkg::STATUS_OK,    0,   20},
        '{bfa_pkg::ACT_ALLOC, 40,   0,    0,    1, bfa_pkg::STATUS_OK,    100, 0},
        '{bfa_pkg::ACT_FREE,  4096, 0,    0,    1, bfa_pkg::STATUS_OK,    0,   2048},
        '{bfa_pkg::ACT_ALLOC, 10,   0,    0,    0, bfa_pkg::STATUS_OK,    0,   0},
        '{bfa_pkg::ACT_ALLOC, 6,    48,   0,    0, bfa_pkg::STATUS_OK,    0,   0},
        '{bfa_pkg::ACT_ALLOC, 3,    3,    0,    0, bfa_pkg::STATUS_OK,    0,   0},
        '{bfa_pkg::ACT_ALLOC, 1,    1,    0,    0, bfa_pkg::STATUS_OK,    0,   0},
        '{bfa_pkg::ACT_ALLOC, 8,    4096, 0,    0, bfa_pkg::STATUS_OK,    0,   0},
        '{bfa_pkg::ACT_ALLOC, 100,  8191, 0,    0, bfa_pkg::STATUS_OK,    0,   0},
        '{bfa_pkg::ACT_ALLOC, 2,    2,    2047, 0, bfa_pkg::STATUS_OK,    0,   0},
        '{bfa_pkg::ACT_FREE,  10,   0,    0,    0, bfa_pkg::STATUS_OK,    0,   0},
        '{bfa_pkg::ACT_FREE,  10,   0,    0,    0, bfa_pkg::STATUS_OK,    0,   0},
        '{bfa_pkg::ACT_FREE,  3,    0,    6,    0, bfa_pkg::STATUS_OK,    0,   0},
        '{bfa_pkg::ACT_FREE,  2,    0,    2047, 0, bfa_pkg::STATUS_OK,    0,   0},
        '{bfa_pkg::ACT_ALLOC, 7,    2,    0,    0, bfa_pkg::STATUS_OK,    0,   0},
        '{bfa_pkg::ACT_FREE,  8191, 0,    5,    0, bfa_pkg::STATUS_OK,    0,   0},
        '{bfa_pkg::ACT_FREE,  8191, 8191, 0,    1, bfa_pkg::STATUS_OK,    0,   2044}
    };

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: random stalls, then check each beat against the oldest expectation
    initial begin
        alloc_res_t want;
        int         stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected beat count", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status)
                    report_mismatch("status", m_status, want.status);
                if (m_granted_offset !== want.granted)
                    report_mismatch("granted_offset", m_granted_offset, want.granted);
                if (m_free_total !== want.total)
                    report_mismatch("free_total", m_free_total, want.total);
            end
        end
    end

    initial begin
        req_item_t  it;
        alloc_res_t known;
        int         gap;
        no_idle = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_action = bfa_pkg::ACT_ALLOC;
        s_size_bytes = '0;
        s_align_bytes = '0;
        s_block_offset = '0;
        arena_clear();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) begin
            it = '{directed[i].action, directed[i].size, directed[i].align, directed[i].offset};
            known.status = directed[i].status;
            known.granted = directed[i].granted[10:0];
            known.total = directed[i].total[11:0];
            send_item(it, $urandom_range(0, 16), directed[i].typed, known);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            no_idle = (n >= 100 && n < 140);
            // hold off until the block has drained
            if (n == 200) begin
                s_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge aclk);
            end
            gap = no_idle ? 0 : $urandom_range(0, 16);
            send_item(random_request(), gap, 1'b0, known);
        end
        s_valid <= 1'b0;
        no_idle = 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

>>> filelist.f
rtl/bfa_pkg.sv
rtl/bfa_arena.sv
rtl/bfa_seq.sv
rtl/best_fit_block_allocator.sv
rtl/bfa_checker.sv
tb/tb_top.sv
